FILE: hdl/ppas_pkg.sv
// Shared types and constants of the priority scheduler with aging.
package ppas_pkg;

   localparam int CFG_BITS = 8;
   localparam int PRIO_BITS = 8;
   localparam int WAIT_BITS = 8;
   localparam int FIELD_BITS = 16;
   localparam int AGED_BITS = 5;
   localparam int IN_SLOT_BITS = 4;

   localparam logic [1:0] REG_AGE_LIMIT = 2'd0;
   localparam logic [1:0] REG_AGING_STEP = 2'd1;
   localparam logic [1:0] REG_PRIORITY_FLOOR = 2'd2;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = 8'd5;
   localparam logic [CFG_BITS-1:0] STEP_RESET = 8'd1;
   localparam logic [CFG_BITS-1:0] FLOOR_RESET = 8'd1;

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // write the request word into its slot
      logic sweep;     // age and compare the slot under the cursor
      logic finish;    // apply the pick and build the response
   } ppas_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic sweep_last;
   } ppas_sts_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] now;
      logic idle;
      logic [IN_SLOT_BITS-1:0] running_slot;
      logic preempted;
      logic [IN_SLOT_BITS-1:0] preempted_slot;
      logic first_start;
      logic [FIELD_BITS-1:0] response_time;
      logic finished;
      logic [FIELD_BITS-1:0] turnaround;
      logic [FIELD_BITS-1:0] waiting_time;
      logic [AGED_BITS-1:0] aged_count;
   } ppas_rsp_type;

   typedef struct packed {
      logic action;
      logic [IN_SLOT_BITS-1:0] slot;
      logic [FIELD_BITS-1:0] arrival;
      logic [FIELD_BITS-1:0] burst;
      logic [PRIO_BITS-1:0] priority_req;
   } ppas_req_type;

endpackage

FILE: hdl/ppas_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
interface ppas_req_if import ppas_pkg::*; ();
   logic valid;
   logic ready;
   ppas_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ppas_rsp_if import ppas_pkg::*; ();
   logic valid;
   logic ready;
   ppas_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ppas_csr_if import ppas_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [CFG_BITS-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: hdl/ppas_ctrl.sv
// Controller sequencing loads and slot sweeps of each tick.
module ppas_ctrl import ppas_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_action,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  ppas_sts_type sts,
   output ppas_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_FIN   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // advance through the tick sequence
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACTION_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

FILE: hdl/ppas_dp.sv
// Datapath: task table, aging sweep, priority search and result build.
module ppas_dp import ppas_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  ppas_cmd_type cmd,
   input  ppas_req_type req,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata,
   output ppas_sts_type sts,
   output ppas_rsp_type rsp
);

   localparam int SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CB = $clog2(SLOTS + 1);

   logic [CFG_BITS-1:0] thr_ff, step_ff, floor_ff;

   // per-slot tables
   logic [SLOTS-1:0] valid_ff, started_ff, done_ff;
   logic [FIELD_BITS-1:0] arrival_ff [SLOTS];
   logic [FIELD_BITS-1:0] burst_ff [SLOTS];
   logic [FIELD_BITS-1:0] remain_ff [SLOTS];
   logic [PRIO_BITS-1:0] prio_ff [SLOTS];
   logic [WAIT_BITS-1:0] wait_ff [SLOTS];

   logic [TIME_BITS-1:0] time_ff;
   logic last_valid_ff;
   logic [SB-1:0] last_slot_ff;

   logic [CB-1:0] cur_ff;
   logic found_ff;
   logic [SB-1:0] pick_ff;
   logic [PRIO_BITS-1:0] best_ff;
   logic [AGED_BITS-1:0] aged_ff;
   ppas_rsp_type rsp_ff;
   ppas_rsp_type rsp_in;

   logic [SB-1:0] cur;
   logic cur_ready;
   logic [WAIT_BITS-1:0] wait_inc;
   logic age_now;
   logic [PRIO_BITS-1:0] prio_new;
   logic [PRIO_BITS:0] gap;
   logic load_ok;
   logic [SB-1:0] load_slot;
   logic pre_hit;
   logic [FIELD_BITS-1:0] start16, end16, tat, rem_dec;

   assign cur = cur_ff[SB-1:0];
   assign sts.sweep_last = (cur_ff == CB'(SLOTS - 1));
   assign rsp = rsp_ff;
   assign load_slot = SB'(req.slot);
   assign load_ok = ({1'b0, req.slot} < 5'(SLOTS)) || (SLOTS > 16);

   // age the slot under the cursor
   always_comb begin
      cur_ready = valid_ff[cur] && !done_ff[cur]
                  && (32'(arrival_ff[cur]) <= 32'(time_ff));
      wait_inc = wait_ff[cur];
      if (!(last_valid_ff && last_slot_ff == cur) && wait_ff[cur] != '1)
         wait_inc = wait_ff[cur] + 1'b1;
      age_now = (wait_inc > thr_ff) && (prio_ff[cur] > floor_ff);
      gap = {1'b0, prio_ff[cur]} - {1'b0, floor_ff};
      prio_new = (gap > {1'b0, step_ff}) ? prio_ff[cur] - step_ff : floor_ff;
      if (!age_now) prio_new = prio_ff[cur];
   end

   assign start16 = FIELD_BITS'(time_ff);
   assign end16 = FIELD_BITS'(time_ff + 1'b1);
   assign tat = end16 - arrival_ff[pick_ff];
   assign rem_dec = remain_ff[pick_ff] - 1'b1;

   // build the response word of the tick
   always_comb begin
      pre_hit = last_valid_ff && last_slot_ff != pick_ff && valid_ff[last_slot_ff]
                && !done_ff[last_slot_ff] && remain_ff[last_slot_ff] != '0;
      rsp_in = '0;
      rsp_in.now = start16;
      rsp_in.idle = !found_ff;
      rsp_in.aged_count = aged_ff;
      if (found_ff) begin
         rsp_in.running_slot = IN_SLOT_BITS'(pick_ff);
         if (pre_hit) begin
            rsp_in.preempted = 1'b1;
            rsp_in.preempted_slot = IN_SLOT_BITS'(last_slot_ff);
         end
         if (!started_ff[pick_ff]) begin
            rsp_in.first_start = 1'b1;
            rsp_in.response_time = start16 - arrival_ff[pick_ff];
         end
         if (rem_dec == '0) begin
            rsp_in.finished = 1'b1;
            rsp_in.turnaround = tat;
            rsp_in.waiting_time = tat - burst_ff[pick_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         step_ff <= STEP_RESET;
         floor_ff <= FLOOR_RESET;
         valid_ff <= '0;
         started_ff <= '0;
         done_ff <= '0;
         time_ff <= '0;
         last_valid_ff <= 1'b0;
         last_slot_ff <= '0;
         cur_ff <= '0;
         found_ff <= 1'b0;
         aged_ff <= '0;
         for (int i = 0; i < SLOTS; i++) wait_ff[i] <= '0;
      end else begin
         // take register writes
         if (csr_we) begin
            case (csr_index)
               REG_AGE_LIMIT: thr_ff <= csr_wdata;
               REG_AGING_STEP: step_ff <= csr_wdata;
               REG_PRIORITY_FLOOR: floor_ff <= csr_wdata;
               default: ;
            endcase
         end
         // write a loaded task
         if (cmd.load && load_ok) begin
            valid_ff[load_slot] <= 1'b1;
            arrival_ff[load_slot] <= req.arrival;
            burst_ff[load_slot] <= req.burst;
            remain_ff[load_slot] <= req.burst;
            prio_ff[load_slot] <= req.priority_req;
            wait_ff[load_slot] <= '0;
            started_ff[load_slot] <= 1'b0;
            done_ff[load_slot] <= (req.burst == '0);
            if (last_valid_ff && last_slot_ff == load_slot) last_valid_ff <= 1'b0;
         end
         // sweep one slot: age, then compare
         if (cmd.sweep) begin
            cur_ff <= sts.sweep_last ? '0 : cur_ff + 1'b1;
            if (cur_ready) begin
               wait_ff[cur] <= age_now ? '0 : wait_inc;
               prio_ff[cur] <= prio_new;
               if (age_now && aged_ff != '1) aged_ff <= aged_ff + 1'b1;
               if (!found_ff || prio_new < best_ff) begin
                  found_ff <= 1'b1;
                  pick_ff <= cur;
                  best_ff <= prio_new;
               end
            end
         end
         // apply the pick and hold the response word
         if (cmd.finish) begin
            rsp_ff <= rsp_in;
            if (found_ff) begin
               started_ff[pick_ff] <= 1'b1;
               remain_ff[pick_ff] <= rem_dec;
               wait_ff[pick_ff] <= '0;
               last_valid_ff <= 1'b1;
               last_slot_ff <= pick_ff;
               if (rem_dec == '0) done_ff[pick_ff] <= 1'b1;
            end
            time_ff <= time_ff + 1'b1;
            found_ff <= 1'b0;
            aged_ff <= '0;
         end
      end
   end

endmodule

FILE: hdl/preemptive_priority_aging_scheduler_core.sv
// Top level of the preemptive priority scheduler with aging.
// Usage:
//  req: a word with action 0 loads a task into a slot (no response);
//   action 1 advances time one tick and yields one rsp word.
//  csr: register writes (0 age limit, 1 aging step, 2 priority floor),
//   taken in any cycle; write only while no tick is in flight.
//  Tick sequence: accept in ST_IDLE, a sweep of all SLOTS slots one at a time
//   (aging and minimum search share the per-slot unit), a finish state, then
//   the rsp word is shown.
//  The block takes one word at a time; req_ready stays low while a tick is
//   in work or its rsp word waits. A stalled receiver holds rsp steady.
//  Reset (synchronous): all slots empty, time zero, registers at their
//   defaults (5, 1, 1), no task ran last.
module preemptive_priority_aging_scheduler_core import ppas_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int TIME_BITS = 16
) (
   input logic clock,
   input logic reset,
   ppas_req_if.sink req_ch,
   ppas_rsp_if.source rsp_ch,
   ppas_csr_if.sink csr_ch
);

   ppas_cmd_type cmd;
   ppas_sts_type sts;

   assign csr_ch.ready = 1'b1;

   ppas_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_action(req_ch.data.action),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .sts(sts),
      .cmd(cmd)
   );

   ppas_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .req(req_ch.data),
      .csr_we(csr_ch.valid),
      .csr_index(csr_ch.index),
      .csr_wdata(csr_ch.wdata),
      .sts(sts),
      .rsp(rsp_ch.data)
   );

endmodule

FILE: tb/sv/tb_preemptive_priority_aging_scheduler_core.sv
// Testbench of the priority scheduler with aging: predicts every tick word and checks it.
module tb_preemptive_priority_aging_scheduler_core import ppas_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Tracks the task table and holds the tick words still to come
   class sched_scoreboard;
      bit [CFG_BITS-1:0] threshold = THRESHOLD_RESET;
      bit [CFG_BITS-1:0] step = STEP_RESET;
      bit [CFG_BITS-1:0] floor_prio = FLOOR_RESET;
      bit slot_used [16];
      bit [FIELD_BITS-1:0] arrival [16];
      bit [FIELD_BITS-1:0] burst [16];
      bit [FIELD_BITS-1:0] remaining [16];
      bit [PRIO_BITS-1:0] prio [16];
      bit [WAIT_BITS-1:0] waited [16];
      bit started [16];
      bit done [16];
      bit [FIELD_BITS-1:0] now;
      bit last_ran;
      bit [IN_SLOT_BITS-1:0] last_slot;
      ppas_rsp_type tick_words [$];
      int errors;

      function void write_reg(logic [1:0] index, bit [CFG_BITS-1:0] value);
         case (index)
            REG_AGE_LIMIT: threshold = value;
            REG_AGING_STEP: step = value;
            REG_PRIORITY_FLOOR: floor_prio = value;
            default: ;
         endcase
      endfunction

      function bit runnable(int i);
         return slot_used[i] && !done[i] && arrival[i] <= now;
      endfunction

      // Apply an accepted request word; a tick queues its expected response
      function void note_req(ppas_req_type w);
         ppas_rsp_type r;
         int aged;
         int pick;
         bit found;
         int s;
         if (w.action == ACTION_LOAD) begin
            s = w.slot;
            slot_used[s] = 1;
            arrival[s] = w.arrival;
            burst[s] = w.burst;
            remaining[s] = w.burst;
            prio[s] = w.priority_req;
            waited[s] = 0;
            started[s] = 0;
            done[s] = (w.burst == 0);
            if (last_ran && last_slot == s) last_ran = 0;
            return;
         end
         r = '0;
         aged = 0;
         found = 0;
         pick = 0;
         r.now = now;
         // age every waiting task
         for (int i = 0; i < 16; i++) begin
            if (!runnable(i)) continue;
            if (!(last_ran && last_slot == i) && waited[i] < 255) waited[i]++;
            if (waited[i] > threshold && prio[i] > floor_prio) begin
               if (int'(prio[i]) - int'(floor_prio) > int'(step)) prio[i] = prio[i] - step;
               else prio[i] = floor_prio;
               waited[i] = 0;
               if (aged < 31) aged++;
            end
         end
         // pick the best ready task, ties to the lowest slot
         for (int i = 0; i < 16; i++) begin
            if (runnable(i) && (!found || prio[i] < prio[pick])) begin
               found = 1;
               pick = i;
            end
         end
         r.idle = !found;
         if (found) begin
            r.running_slot = IN_SLOT_BITS'(pick);
            if (last_ran && last_slot != pick && slot_used[last_slot] && !done[last_slot]
                  && remaining[last_slot] > 0) begin
               r.preempted = 1;
               r.preempted_slot = last_slot;
            end
            if (!started[pick]) begin
               started[pick] = 1;
               r.first_start = 1;
               r.response_time = now - arrival[pick];
            end
            remaining[pick]--;
            waited[pick] = 0;
            last_ran = 1;
            last_slot = IN_SLOT_BITS'(pick);
            if (remaining[pick] == 0) begin
               done[pick] = 1;
               r.finished = 1;
               r.turnaround = now + 16'd1 - arrival[pick];
               r.waiting_time = r.turnaround - burst[pick];
            end
         end
         r.aged_count = AGED_BITS'(aged);
         now++;
         tick_words = {tick_words, r};
      endfunction

      function void field(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Compare a response word against the oldest expected one
      function void check_rsp(ppas_rsp_type got);
         ppas_rsp_type want;
         if (tick_words.size() == 0) begin
            $display("%0t: unexpected response word expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = tick_words.pop_front();
         field("now", want.now, got.now);
         field("idle", want.idle, got.idle);
         field("running_slot", want.running_slot, got.running_slot);
         field("preempted", want.preempted, got.preempted);
         field("preempted_slot", want.preempted_slot, got.preempted_slot);
         field("first_start", want.first_start, got.first_start);
         field("response_time", want.response_time, got.response_time);
         field("finished", want.finished, got.finished);
         field("turnaround", want.turnaround, got.turnaround);
         field("waiting_time", want.waiting_time, got.waiting_time);
         field("aged_count", want.aged_count, got.aged_count);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   ppas_req_if req_bus ();
   ppas_rsp_if rsp_bus ();
   ppas_csr_if csr_bus ();

   sched_scoreboard sb = new();
   bit no_gaps;
   int rsp_hold;
   int sent;

   preemptive_priority_aging_scheduler_core uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_ch(csr_bus)
   );

   always #4 clock = ~clock;

   // Drive one request word, idling first, and note it once accepted
   task send_req(ppas_req_type w);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1;
      req_bus.data = w;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_req(w);
      sent++;
      @(negedge clock);
   endtask

   task load(int s, int arr, int bst, int p);
      ppas_req_type w;
      w = '0;
      w.action = ACTION_LOAD;
      w.slot = IN_SLOT_BITS'(s);
      w.arrival = FIELD_BITS'(arr);
      w.burst = FIELD_BITS'(bst);
      w.priority_req = PRIO_BITS'(p);
      send_req(w);
   endtask

   task tick();
      ppas_req_type w;
      w = $urandom;
      w.action = ACTION_TICK;
      send_req(w);
   endtask

   // Drop valid and hold until every tick word has come back
   task drain();
      req_bus.valid = 0;
      while (sb.tick_words.size() > 0) @(posedge clock);
      repeat (25) @(negedge clock);
   endtask

   task write_reg(logic [1:0] index, int value);
      csr_bus.valid = 1;
      csr_bus.index = index;
      csr_bus.wdata = CFG_BITS'(value);
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(index, CFG_BITS'(value));
      @(negedge clock);
      csr_bus.valid = 0;
   endtask

   task set_regs(int thr, int stp, int flr);
      write_reg(REG_AGE_LIMIT, thr);
      write_reg(REG_AGING_STEP, stp);
      write_reg(REG_PRIORITY_FLOOR, flr);
   endtask

   // Loads of fresh tasks, mostly arriving near the current time, then a run of ticks
   task random_batch();
      int n;
      int arr;
      int bst;
      int pick;
      n = $urandom_range(1, 4);
      repeat (n) begin
         pick = $urandom_range(0, 19);
         arr = (pick == 0) ? $urandom : sb.now + $urandom_range(0, 3);
         pick = $urandom_range(0, 19);
         bst = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 65535) : $urandom_range(1, 6);
         load($urandom_range(0, 15), arr, bst, $urandom_range(1, 255));
      end
      n = $urandom_range(1, 8);
      repeat (n) tick();
   endtask

   // Accept response words with random stalls and an occasional long hold-off
   initial begin
      int gap;
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            gap = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
         end
         rsp_bus.ready = 0;
         repeat (gap) @(negedge clock);
         rsp_bus.ready = 1;
         do @(posedge clock); while (!rsp_bus.valid);
         sb.check_rsp(rsp_bus.data);
      end
   end

   initial begin
      req_bus.valid = 0;
      req_bus.data = '0;
      csr_bus.valid = 0;
      csr_bus.index = REG_AGE_LIMIT;
      csr_bus.wdata = '0;
      repeat (12) @(negedge clock);
      reset = 0;

      // directed: extremes, zero burst, reload of the running slot, preemption, idle
      set_regs(5, 1, 1);
      load(15, 0, 3, 255);
      load(7, 65535, 65535, 128);
      load(3, 0, 0, 1);
      tick();
      load(0, 0, 1, 1);
      tick();
      tick();
      load(15, 0, 2, 200);
      tick();
      load(5, 0, 2, 1);
      tick();
      tick();
      load(9, sb.now + 3, 1, 2);
      tick();
      tick();
      repeat (12) tick();
      drain();

      // random phases over several register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_regs(0, 255, 1);
            1: set_regs(255, 1, 255);
            2: set_regs(0, 1, 1);
            3: set_regs(2, 3, 10);
            4: set_regs(1, 255, 255);
            default: set_regs($urandom_range(0, 255), $urandom_range(1, 255),
                  $urandom_range(1, 255));
         endcase
         no_gaps = (ph == 2);
         if (ph == 3) rsp_hold = 300;
         while (sent < 100 + (ph + 1) * 205) random_batch();
         drain();
      end

      if (sb.errors == 0 && sb.tick_words.size() == 0) begin
         $display("tb_preemptive_priority_aging_scheduler_core passed");
      end else begin
         if (sb.tick_words.size() > 0)
            $display("%0t: %0d response words expected actual none", $time,
                  sb.tick_words.size());
         $display("tb_preemptive_priority_aging_scheduler_core failed");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #20000000;
      $display("tb_preemptive_priority_aging_scheduler_core failed");
      $finish;
   end
endmodule
